/* hw/rtl/fwdf_pkg.sv */
package fwdf_pkg;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_CR   = 8'h0D;

  // q = (v * 52429) >> 19 is exact for every 16-bit v
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } fsm_e;

endpackage

/* hw/rtl/fwdf_div10.sv */
module fwdf_div10 (
  input  logic [15:0] value_i,
  output logic [15:0] quot_o,
  output logic [3:0]  rem_o
);
  import fwdf_pkg::*;

  logic [32:0] prod;
  logic [15:0] times_ten;

  assign prod      = 33'(value_i) * 33'(DIV10_MUL);
  assign quot_o    = 16'(prod >> DIV10_SHIFT);
  assign times_ten = 16'({quot_o, 3'b000}) + 16'({quot_o, 1'b0});
  assign rem_o     = 4'(value_i - times_ten);

endmodule

/* hw/rtl/fixed_width_decimal_formatter.sv */
// Fixed-width decimal formatter: 16-bit unsigned value to ASCII decimal bytes.
// Input: drive value_i, digit_count_i and fill_char_i with start high; the item
// is taken at the rising edge where start is high and busy is low. busy stays
// high until the last byte of the item has been shown.
// Output: each byte is on out_byte_o for exactly one cycle with out_valid_o
// high; last_o marks the final byte of the item. There is no backpressure:
// the receiver must take every byte in the cycle it appears.
// Timing: with n = min(digit_count_i, MAX_DIGITS), the shared divide-by-10
// unit (one reciprocal multiply) produces one digit per cycle, so conversion
// yields n digits; emission then sends the bytes back to back (a fill byte of
// newline goes out as CR, LF); busy falls the cycle after the last byte. A
// digit count of zero produces no bytes and leaves busy low.
// Reset: rst_ni clears the sequencer to idle; no byte is pending afterwards.
module fixed_width_decimal_formatter #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] value_i,
  input  logic [3:0]  digit_count_i,
  input  logic [7:0]  fill_char_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import fwdf_pkg::*;

  localparam int CntW = $clog2(MAX_DIGITS + 1);
  localparam int CmpW = (CntW > 4) ? CntW : 4;
  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  fsm_e state_q, state_d;

  logic [15:0]     value_q, value_d;
  logic [7:0]      fill_q, fill_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] top_q, top_d;
  logic            lead_q, lead_d;
  logic            cr_q, cr_d;
  logic [3:0]      digit_q [MAX_DIGITS];

  logic [15:0]     quot;
  logic [3:0]      rem;
  logic            accept;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] cnt_sat;
  logic            cnt_zero;
  logic [3:0]      cur_digit;
  logic            is_fill;
  logic [7:0]      cur_byte;
  logic            need_cr;
  logic            conv_done;
  logic            emit_done;

  fwdf_div10 u_div10 (
    .value_i(value_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign cnt_ext   = CmpW'(digit_count_i);
  assign cnt_sat   = (cnt_ext > CmpW'(MAX_DIGITS)) ? CmpW'(MAX_DIGITS) : cnt_ext;
  assign cnt_zero  = (cnt_sat == '0);
  assign cur_digit = digit_q[idx_q];
  assign is_fill   = lead_q && (idx_q != '0) && (cur_digit == 4'd0);
  assign cur_byte  = is_fill ? fill_q : (ASCII_ZERO | 8'(cur_digit));
  assign need_cr   = (cur_byte == ASCII_LF) && !cr_q;
  assign conv_done = (idx_q == top_q);
  assign emit_done = (idx_q == '0) && !need_cr;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !cnt_zero) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    value_d     = value_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    top_d       = top_q;
    lead_d      = lead_q;
    cr_d        = cr_q;
    out_valid_o = 1'b0;
    out_byte_o  = cur_byte;
    last_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        value_d = value_i;
        fill_d  = fill_char_i;
        idx_d   = '0;
        top_d   = IdxW'(cnt_sat - CmpW'(1));
        lead_d  = 1'b1;
        cr_d    = 1'b0;
      end
      ST_CONV: begin
        value_d = quot;
        if (!conv_done) begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (need_cr) begin
          out_byte_o = ASCII_CR;
          cr_d       = 1'b1;
        end else begin
          cr_d   = 1'b0;
          lead_d = is_fill;
          last_o = (idx_q == '0);
          if (idx_q != '0) begin
            idx_d = idx_q - IdxW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      top_q   <= '0;
      lead_q  <= 1'b1;
      cr_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      top_q   <= top_d;
      lead_q  <= lead_d;
      cr_q    <= cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    fill_q  <= fill_d;
    if (state_q == ST_CONV) begin
      digit_q[idx_q] <= rem;
    end
  end

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy)
    else $error("byte strobe outside an item");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && digit_count_i == 4'd0) |=> !busy)
    else $error("zero digit count left the block busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> (!out_valid_o && !busy))
    else $error("activity after the last byte");

  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (out_byte_o >= ASCII_ZERO && out_byte_o <= ASCII_NINE))
    else $error("final byte is not a digit");
`endif

endmodule

/* tb/decimal_byte_checker.sv */
`timescale 1ns / 100ps

module decimal_byte_checker #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [15:0] value_i,
  input  logic [3:0]  digit_count_i,
  input  logic [7:0]  fill_char_i,
  input  logic        out_valid_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  output int          mismatch_cnt_o,
  output int          bytes_due_o
);
  import fwdf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fmt_byte_t;

  fmt_byte_t due_bytes_q[$];
  int        mismatch_cnt;

  // Expected byte stream for one item, appended to the queue of due bytes.
  function automatic void format_value(input logic [15:0] value, input logic [3:0] count,
                                       input logic [7:0] fill);
    logic [7:0] digits[MAX_DIGITS];
    fmt_byte_t  seq[$];
    int         n;
    int         v;
    n = (count > MAX_DIGITS) ? MAX_DIGITS : int'(count);
    v = int'(value);
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      digits[n - 1 - i] = ASCII_ZERO + 8'(v % 10);
      v = v / 10;
    end
    for (int i = 0; i + 1 < n; i++) begin
      if (digits[i] != ASCII_ZERO) break;
      digits[i] = fill;
    end
    for (int i = 0; i < n; i++) begin
      if (digits[i] == ASCII_LF) seq.push_back('{ch: ASCII_CR, last: 1'b0});
      seq.push_back('{ch: digits[i], last: 1'b0});
    end
    seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i]) due_bytes_q.push_back(seq[i]);
  endfunction

  always @(posedge clk_i) begin
    fmt_byte_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) format_value(value_i, digit_count_i, fill_char_i);
      if (out_valid_i) begin
        if (due_bytes_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected byte: expected none, actual byte=%02h last=%0b",
                   $time, out_byte_i, last_i);
        end else begin
          want = due_bytes_q.pop_front();
          if (out_byte_i !== want.ch) begin
            mismatch_cnt++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.ch, out_byte_i);
          end
          if (last_i !== want.last) begin
            mismatch_cnt++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, last_i);
          end
        end
      end
      mismatch_cnt_o <= mismatch_cnt;
      bytes_due_o    <= due_bytes_q.size();
    end
  end

endmodule

/* tb/fixed_width_decimal_formatter_tb.sv */
`timescale 1ns / 100ps

module fixed_width_decimal_formatter_tb;
  import fwdf_pkg::*;

  localparam int MAX_DIGITS = 10;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 3 * MAX_DIGITS + 10;
  localparam int RANDOM_ITEMS = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] value_i = '0;
  logic [3:0]  digit_count_i = '0;
  logic [7:0]  fill_char_i = '0;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  int          mismatch_cnt;
  int          bytes_due;
  int          idle_pct = 22;
  int          stall_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  fixed_width_decimal_formatter #(.MAX_DIGITS(MAX_DIGITS)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .fill_char_i  (fill_char_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  decimal_byte_checker #(.MAX_DIGITS(MAX_DIGITS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .fill_char_i   (fill_char_i),
    .out_valid_i   (out_valid_o),
    .out_byte_i    (out_byte_o),
    .last_i        (last_o),
    .mismatch_cnt_o(mismatch_cnt),
    .bytes_due_o   (bytes_due)
  );

  task automatic send_number(input logic [15:0] value, input logic [3:0] count,
                             input logic [7:0] fill);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    value_i       <= value;
    digit_count_i <= count;
    fill_char_i   <= fill;
    do @(posedge clk_i); while (busy);
  endtask

  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [15:0] value;
    logic [3:0]  count;
    logic [7:0]  fill;
    int          pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_number(16'd0, 4'd1, " ");
    send_number(16'd0, 4'd0, " ");
    send_number(16'd65535, 4'd0, ASCII_LF);
    send_number(16'd65535, 4'd5, " ");
    send_number(16'd65535, 4'd10, " ");
    send_number(16'd65535, 4'd15, 8'hFF);
    send_number(16'd32768, 4'd11, "*");
    send_number(16'd0, 4'd10, ASCII_LF);
    send_number(16'd0, 4'd15, ASCII_LF);
    send_number(16'd0, 4'd10, ASCII_ZERO);
    send_number(16'd1000, 4'd8, ASCII_ZERO);
    send_number(16'd1234, 4'd3, "*");
    send_number(16'd1234, 4'd2, ASCII_LF);
    send_number(16'd100, 4'd6, 8'h00);
    send_number(16'd10, 4'd2, ASCII_LF);
    send_number(16'd5, 4'd4, ASCII_LF);
    send_number(16'd7, 4'd1, ASCII_LF);
    send_number(16'd40000, 4'd5, ASCII_LF);
    send_number(16'd1, 4'd9, ASCII_CR);
    send_number(16'd21845, 4'd7, 8'hAA);
    send_number(16'd43690, 4'd6, 8'h55);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i >= 80 && i < 140) ? 0 : 22;
      pick = $urandom_range(99);
      value = (pick < 25) ? 16'($urandom_range(99)) : 16'($urandom);
      pick = $urandom_range(99);
      count = (pick < 80) ? 4'($urandom_range(1, MAX_DIGITS)) : 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) fill = ASCII_LF;
      else if (pick < 45) fill = ASCII_ZERO;
      else if (pick < 60) fill = " ";
      else fill = 8'($urandom);
      send_number(value, count, fill);
    end
    start <= 1'b0;

    do @(posedge clk_i); while (bytes_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && bytes_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
